FILE: rtl/rpn_four_level_stack_alu_defines.svh
// ----------------------------------------------------------------------------
// RPN stack ALU assertion macros
// Shared assertion helpers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RPN_FOUR_LEVEL_STACK_ALU_DEFINES_SVH
`define RPN_FOUR_LEVEL_STACK_ALU_DEFINES_SVH

// same-cycle implication
`define RSALU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSALU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rsalu_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack ALU package
// Item types, function codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package rsalu_pkg;

	localparam int RSALU_WORD_BITS  = 32;
	localparam int RSALU_FRAC_BITS  = 16;
	localparam int RSALU_FIELD_BITS = 32;

	typedef enum logic [2:0] {
		FN_PUSH = 3'd0,
		FN_ADD  = 3'd1,
		FN_SUB  = 3'd2,
		FN_MUL  = 3'd3,
		FN_DIV  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_RES,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		UM_ADD,
		UM_SUB,
		UM_MUL,
		UM_DIV
	} unit_mode_t;

	typedef struct packed {
		logic       load;
		logic       step;
		unit_mode_t mode;
	} unit_ctl_t;

	typedef struct packed {
		logic [2:0]                         func;
		logic signed [RSALU_FIELD_BITS-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [RSALU_FIELD_BITS-1:0] reg_x;
		logic signed [RSALU_FIELD_BITS-1:0] reg_y;
		logic signed [RSALU_FIELD_BITS-1:0] reg_z;
		logic signed [RSALU_FIELD_BITS-1:0] reg_t;
		logic                               div_zero;
		logic                               saturated;
	} res_item_t;

endpackage

FILE: rtl/rsalu_stream_if.sv
// ----------------------------------------------------------------------------
// RPN stack ALU stream channel
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface rsalu_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/rsalu_iter_unit.sv
// ----------------------------------------------------------------------------
// RPN stack ALU shared arithmetic unit
// One adder/subtractor used for add, subtract, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module rsalu_iter_unit import rsalu_pkg::*; #(
	parameter int WORD_BITS = RSALU_WORD_BITS,
	parameter int FRAC_BITS = RSALU_FRAC_BITS
) (
	input  logic                                clk,
	input  unit_ctl_t                           ctl,
	input  logic signed [WORD_BITS-1:0]         opnd_y,
	input  logic signed [WORD_BITS-1:0]         opnd_x,
	output logic [WORD_BITS+1:0]                sum,
	output logic [2*WORD_BITS-1:0]              prod,
	output logic [WORD_BITS+FRAC_BITS-1:0]      quot
);

	localparam int W  = WORD_BITS;
	localparam int QW = WORD_BITS + FRAC_BITS;
	localparam int SW = WORD_BITS + 2;

	logic [W-1:0]  mag_y;
	logic [W-1:0]  mag_x;
	logic [W-1:0]  acc_q;
	logic [QW-1:0] sh_q;
	logic [QW-1:0] sh_mul;
	logic [SW-1:0] op_a;
	logic [SW-1:0] op_b;
	logic          sub;
	logic          ge;

	assign mag_y = opnd_y[W-1] ? ($unsigned(~opnd_y) + 1'b1) : $unsigned(opnd_y);
	assign mag_x = opnd_x[W-1] ? ($unsigned(~opnd_x) + 1'b1) : $unsigned(opnd_x);

	always_comb begin
		case (ctl.mode)
			UM_ADD: begin
				op_a = SW'(opnd_y);
				op_b = SW'(opnd_x);
				sub  = 1'b0;
			end
			UM_SUB: begin
				op_a = SW'(opnd_y);
				op_b = SW'(opnd_x);
				sub  = 1'b1;
			end
			UM_MUL: begin
				op_a = SW'(acc_q);
				op_b = sh_q[0] ? SW'(mag_y) : '0;
				sub  = 1'b0;
			end
			UM_DIV: begin
				op_a = {1'b0, acc_q, sh_q[QW-1]};
				op_b = SW'(mag_x);
				sub  = 1'b1;
			end
			default: begin
				op_a = '0;
				op_b = '0;
				sub  = 1'b0;
			end
		endcase
		sum = op_a + (sub ? ~op_b : op_b) + SW'(sub);
	end

	// no borrow out of the trial subtract
	assign ge = ~sum[SW-1];

	always_comb begin
		sh_mul        = sh_q >> 1;
		sh_mul[W-1]   = sum[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= '0;
			sh_q  <= (ctl.mode == UM_DIV) ? (QW'(mag_y) << FRAC_BITS) : QW'(mag_x);
		end else if (ctl.step) begin
			case (ctl.mode)
				UM_MUL: begin
					acc_q <= sum[W:1];
					sh_q  <= sh_mul;
				end
				UM_DIV: begin
					acc_q <= ge ? sum[W-1:0] : op_a[W-1:0];
					sh_q  <= {sh_q[QW-2:0], ge};
				end
				default: begin
					acc_q <= acc_q;
					sh_q  <= sh_q;
				end
			endcase
		end
	end

	assign prod = {acc_q, sh_q[W-1:0]};
	assign quot = sh_q;

endmodule

FILE: rtl/rpn_four_level_stack_alu.sv
// ----------------------------------------------------------------------------
// RPN four-level stack ALU
// X/Y/Z/T stack in signed fixed point with saturating add, subtract,
// multiply and divide on a shared iterative unit.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | accept
//  cmd     | in  | func, value                                    | valid & ready
//  res     | out | reg_x, reg_y, reg_z, reg_t, div_zero, saturated | valid & ready
//
//  Push, add, subtract, unused codes and divide by zero go from idle straight to output.
//  Multiply: one multiplier bit per cycle in ST_MUL, then ST_RES and ST_OUT.
//  Divide: one quotient bit per cycle in ST_DIV, then ST_RES and ST_OUT.
//  The shared adder loop sets the long cases; cmd is not ready while busy.
//  arst_n clears the stack, flags and output valid; res may stall freely.
// ----------------------------------------------------------------------------
`include "rpn_four_level_stack_alu_defines.svh"

module rpn_four_level_stack_alu import rsalu_pkg::*; #(
	parameter int WORD_BITS = RSALU_WORD_BITS,
	parameter int FRAC_BITS = RSALU_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	rsalu_stream_if.sink   cmd,
	rsalu_stream_if.source res
);

	localparam int W  = WORD_BITS;
	localparam int QW = WORD_BITS + FRAC_BITS;
	localparam int PW = 2 * WORD_BITS;
	localparam int RW = (QW > PW) ? QW : PW;
	localparam int CW = $clog2(QW);

	state_t                state_q, state_d;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q;
	logic                  is_div_q;
	logic                  dz_q;
	logic                  sat_q;
	logic signed [W-1:0]   stack_x_q, stack_y_q, stack_z_q, stack_t_q;
	res_item_t             out_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  out_load;
	logic                  x_zero;
	unit_ctl_t             ctl;
	logic [W+1:0]          sum;
	logic [PW-1:0]         prod;
	logic [QW-1:0]         quot;
	logic                  add_ovf;
	logic [W-1:0]          add_res;
	logic [RW-1:0]         res_mag;
	logic [RW-1:0]         lim;
	logic                  res_sat;
	logic [W-1:0]          mag_w;
	logic [W-1:0]          res_word;

	rsalu_iter_unit #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_unit (
		.clk   (clk),
		.ctl   (ctl),
		.opnd_y(stack_y_q),
		.opnd_x(stack_x_q),
		.sum   (sum),
		.prod  (prod),
		.quot  (quot)
	);

	assign x_zero = (stack_x_q == '0);

	// add/sub saturation
	assign add_ovf = !((sum[W+1] == sum[W-1]) && (sum[W] == sum[W-1]));
	assign add_res = add_ovf ? (sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
	                         : sum[W-1:0];

	// mul/div magnitude saturation
	always_comb begin
		res_mag  = is_div_q ? RW'(quot) : RW'(prod >> FRAC_BITS);
		lim      = RW'({1'b0, {(W-1){1'b1}}}) + RW'(neg_q);
		res_sat  = (res_mag > lim);
		mag_w    = res_sat ? lim[W-1:0] : res_mag[W-1:0];
		res_word = neg_q ? (~mag_w + 1'b1) : mag_w;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.item.func)
						FN_MUL:  state_d = ST_MUL;
						FN_DIV:  state_d = x_zero ? ST_OUT : ST_DIV;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_MUL, ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_RES;
				end
			end
			ST_RES: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		accept    = cmd.valid && (state_q == ST_IDLE);
		out_load  = (state_q == ST_OUT) && (!out_valid_q || res.ready);
		ctl.load  = accept && ((cmd.item.func == FN_MUL) ||
		                       ((cmd.item.func == FN_DIV) && !x_zero));
		ctl.step  = (state_q == ST_MUL) || (state_q == ST_DIV);
		case (state_q)
			ST_IDLE: begin
				case (cmd.item.func)
					FN_SUB:  ctl.mode = UM_SUB;
					FN_MUL:  ctl.mode = UM_MUL;
					FN_DIV:  ctl.mode = UM_DIV;
					default: ctl.mode = UM_ADD;
				endcase
			end
			ST_MUL:  ctl.mode = UM_MUL;
			ST_DIV:  ctl.mode = UM_DIV;
			default: ctl.mode = UM_ADD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			is_div_q    <= 1'b0;
			dz_q        <= 1'b0;
			sat_q       <= 1'b0;
			stack_x_q   <= '0;
			stack_y_q   <= '0;
			stack_z_q   <= '0;
			stack_t_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (accept) begin
				case (cmd.item.func)
					FN_PUSH: begin
						dz_q      <= 1'b0;
						sat_q     <= 1'b0;
						stack_t_q <= stack_z_q;
						stack_z_q <= stack_y_q;
						stack_y_q <= stack_x_q;
						stack_x_q <= W'($signed(cmd.item.value));
					end
					FN_ADD, FN_SUB: begin
						dz_q      <= 1'b0;
						stack_x_q <= add_res;
						stack_y_q <= stack_z_q;
						stack_z_q <= stack_t_q;
						sat_q     <= add_ovf;
					end
					FN_MUL: begin
						dz_q     <= 1'b0;
						sat_q    <= 1'b0;
						neg_q    <= stack_y_q[W-1] ^ stack_x_q[W-1];
						is_div_q <= 1'b0;
						cnt_q    <= CW'(W - 1);
					end
					FN_DIV: begin
						dz_q     <= x_zero;
						sat_q    <= 1'b0;
						neg_q    <= stack_y_q[W-1] ^ stack_x_q[W-1];
						is_div_q <= 1'b1;
						cnt_q    <= CW'(QW - 1);
					end
					default: begin
						dz_q  <= 1'b0;
						sat_q <= 1'b0;
					end
				endcase
			end
			if (state_q == ST_RES) begin
				stack_x_q <= res_word;
				stack_y_q <= stack_z_q;
				stack_z_q <= stack_t_q;
				sat_q     <= res_sat;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.reg_x     <= RSALU_FIELD_BITS'(stack_x_q);
			out_q.reg_y     <= RSALU_FIELD_BITS'(stack_y_q);
			out_q.reg_z     <= RSALU_FIELD_BITS'(stack_z_q);
			out_q.reg_t     <= RSALU_FIELD_BITS'(stack_t_q);
			out_q.div_zero  <= dz_q;
			out_q.saturated <= sat_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.item  = out_q;

	`RSALU_ASSERT_NXT(a_busy_after_accept, accept, !cmd.ready, "cmd ready right after accept")
	`RSALU_ASSERT_IMP(a_flags_exclusive, out_valid_q, !(out_q.div_zero && out_q.saturated), "div_zero with saturated")
	`RSALU_ASSERT_NXT(a_dz_keeps_stack, accept && (cmd.item.func == FN_DIV) && x_zero, $stable(stack_x_q) && $stable(stack_y_q) && $stable(stack_z_q) && $stable(stack_t_q), "stack moved on divide by zero")
	`RSALU_ASSERT_NXT(a_res_to_out, state_q == ST_RES, state_q == ST_OUT, "result step not followed by output")
	`RSALU_ASSERT_NXT(a_out_holds, (state_q == ST_OUT) && out_valid_q && !res.ready, state_q == ST_OUT, "output overwritten while stalled")

endmodule

FILE: test/rpn_four_level_stack_alu_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN four-level stack ALU testbench
// Walks a short table of stack operations with hand-derived results at the
// saturation bounds and divide by zero. It then runs random command streams
// under four traffic profiles. Each result item is compared against the
// hand-read stack of a fixed row, else a fixed-point model of the X/Y/Z/T stack.
// ----------------------------------------------------------------------------
module rpn_four_level_stack_alu_tb;
	import rsalu_pkg::*;

	localparam logic [2:0]  FN_SPARE_5 = 3'd5;
	localparam logic [2:0]  FN_SPARE_6 = 3'd6;
	localparam logic [2:0]  FN_SPARE_7 = 3'd7;
	localparam logic [31:0] W_MAX      = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN      = 32'h8000_0000;
	localparam logic [31:0] Q_ONE      = 32'h0001_0000;
	localparam int          N_DIRECTED = 26;
	localparam int          PHASE_OPS  = 238;
	localparam int          DRAIN_WAIT = 60;
	localparam int          CYCLE_CAP  = 400_000;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] value;
		logic        fixed;
		res_item_t   res;
	} step_row_t;

	typedef struct {
		bit        fixed;
		res_item_t res;
	} hint_t;

	// fixed rows carry the stack as read off by hand
	step_row_t directed [N_DIRECTED] = '{
		'{FN_ADD,  32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_DIV,  32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0}},
		'{FN_PUSH, W_MAX, 1'b1, '{W_MAX, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_PUSH, W_MAX, 1'b1, '{W_MAX, W_MAX, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_ADD,  32'h0, 1'b1, '{W_MAX, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
		'{FN_PUSH, W_MIN, 1'b1, '{W_MIN, W_MAX, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_SUB,  32'h0, 1'b1, '{W_MAX, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
		'{FN_PUSH, W_MIN, 1'b1, '{W_MIN, W_MAX, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_MUL,  32'h0, 1'b1, '{W_MIN, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
		'{FN_PUSH, W_MIN, 1'b1, '{W_MIN, W_MIN, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_MUL,  32'h0, 1'b1, '{W_MAX, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
		'{FN_PUSH, Q_ONE, 1'b1, '{Q_ONE, W_MAX, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_DIV,  32'h0, 1'b1, '{W_MAX, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_PUSH, W_MIN, 1'b1, '{W_MIN, W_MAX, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{FN_PUSH, 32'h1, 1'b1, '{32'h1, W_MIN, W_MAX, 32'h0, 1'b0, 1'b0}},
		'{FN_SUB,  32'h0, 1'b1, '{W_MIN, W_MAX, 32'h0, 32'h0, 1'b0, 1'b1}},
		'{FN_PUSH, 32'hFFFF_0000, 1'b0, '0},
		'{FN_DIV,  32'h0, 1'b0, '0},
		'{FN_PUSH, 32'h0001_8000, 1'b0, '0},
		'{FN_PUSH, 32'hFFFE_8000, 1'b0, '0},
		'{FN_MUL,  32'h0, 1'b0, '0},
		'{FN_PUSH, 32'h0000_0003, 1'b0, '0},
		'{FN_DIV,  32'h0, 1'b0, '0},
		'{FN_SPARE_5, 32'hFFFF_FFFF, 1'b0, '0},
		'{FN_SPARE_6, 32'h0, 1'b0, '0},
		'{FN_SPARE_7, 32'h1234_5678, 1'b0, '0}
	};

	int src_idle_by_phase  [4] = '{0, 66, 0, 16};
	int sink_stall_by_phase[4] = '{0, 0, 66, 16};

	logic clk = 1'b0;
	logic arst_n;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int errors         = 0;
	int cycles         = 0;

	logic [31:0] pred_x = '0;
	logic [31:0] pred_y = '0;
	logic [31:0] pred_z = '0;
	logic [31:0] pred_t = '0;

	hint_t     hint_q[$];
	res_item_t want_q[$];

	rsalu_stream_if #(.item_t(cmd_item_t)) cmd_if ();
	rsalu_stream_if #(.item_t(res_item_t)) res_if ();

	rpn_four_level_stack_alu u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout, %0d results outstanding", $time, want_q.size());
			$display("rpn_four_level_stack_alu verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] mag_of(input logic [31:0] v);
		return {32'h0, (v[31] ? -v : v)};
	endfunction

	// advances the modeled stack by one command and returns the new stack
	function automatic res_item_t next_stack(input cmd_item_t c);
		logic [32:0] sum;
		logic [63:0] mag;
		logic [63:0] lim;
		logic [31:0] q;
		bit          neg;
		bit          sat;
		bit          dz;
		bit          lift;
		sat  = 1'b0;
		dz   = 1'b0;
		lift = 1'b0;
		q    = '0;
		mag  = '0;
		neg  = pred_y[31] ^ pred_x[31];
		case (c.func)
			FN_PUSH: begin
				pred_t = pred_z;
				pred_z = pred_y;
				pred_y = pred_x;
				pred_x = c.value;
			end
			FN_ADD, FN_SUB: begin
				if (c.func == FN_ADD)
					sum = {pred_y[31], pred_y} + {pred_x[31], pred_x};
				else
					sum = {pred_y[31], pred_y} - {pred_x[31], pred_x};
				if (sum[32] != sum[31]) begin
					sat = 1'b1;
					q   = sum[32] ? W_MIN : W_MAX;
				end else begin
					q = sum[31:0];
				end
				lift = 1'b1;
			end
			FN_MUL: begin
				mag  = (mag_of(pred_y) * mag_of(pred_x)) >> RSALU_FRAC_BITS;
				lift = 1'b1;
			end
			FN_DIV: begin
				if (pred_x == '0) begin
					dz = 1'b1;
				end else begin
					mag  = (mag_of(pred_y) << RSALU_FRAC_BITS) / mag_of(pred_x);
					lift = 1'b1;
				end
			end
			default: ;
		endcase
		if (lift && (c.func == FN_MUL || c.func == FN_DIV)) begin
			lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			if (mag > lim) begin
				sat = 1'b1;
				mag = lim;
			end
			q = neg ? -mag[31:0] : mag[31:0];
		end
		if (lift) begin
			pred_x = q;
			pred_y = pred_z;
			pred_z = pred_t;
		end
		return '{pred_x, pred_y, pred_z, pred_t, dz, sat};
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : scoreboard
		hint_t     h;
		res_item_t p;
		res_item_t w;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			p = next_stack(cmd_if.item);
			h = hint_q.pop_front();
			want_q.push_back(h.fixed ? h.res : p);
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result item %p", $time, res_if.item);
				errors++;
			end else begin
				w = want_q.pop_front();
				cmp_field("reg_x", w.reg_x, res_if.item.reg_x);
				cmp_field("reg_y", w.reg_y, res_if.item.reg_y);
				cmp_field("reg_z", w.reg_z, res_if.item.reg_z);
				cmp_field("reg_t", w.reg_t, res_if.item.reg_t);
				cmp_field("div_zero", 32'(w.div_zero), 32'(res_if.item.div_zero));
				cmp_field("saturated", 32'(w.saturated), 32'(res_if.item.saturated));
			end
		end
	end

	initial res_if.ready = 1'b0;

	always @(negedge clk)
		res_if.ready <= ($urandom_range(99) >= sink_stall_pct);

	task automatic send_cmd(input logic [2:0] fn, input logic [31:0] val, input bit fixed,
			input res_item_t want);
		hint_t h;
		h.fixed = fixed;
		h.res   = want;
		hint_q.push_back(h);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.item  <= '{func: fn, value: val};
		do @(posedge clk); while (!cmd_if.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		while (want_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		logic [31:0] corner [8] = '{32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF,
			Q_ONE, 32'hFFFF_0000, W_MAX, W_MIN};
		case ($urandom_range(9))
			0, 1:    return corner[$urandom_range(7)];
			2, 3, 4: return $urandom;
			default: return $urandom_range(32'h7_FFFF) - 32'h4_0000;
		endcase
	endfunction

	function automatic logic [2:0] rand_func();
		int r;
		r = $urandom_range(99);
		if (r < 38) return FN_PUSH;
		if (r < 50) return FN_ADD;
		if (r < 62) return FN_SUB;
		if (r < 76) return FN_MUL;
		if (r < 93) return FN_DIV;
		return 3'($urandom_range(FN_SPARE_5, FN_SPARE_7));
	endfunction

	initial begin
		int         n;
		logic [2:0] fn;
		arst_n       = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.item  = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_cmd(directed[i].func, directed[i].value, directed[i].fixed, directed[i].res);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct   = src_idle_by_phase[ph];
			sink_stall_pct = sink_stall_by_phase[ph];
			n = 0;
			while (n < PHASE_OPS) begin
				fn = rand_func();
				n++;
				send_cmd(fn, rand_value(), 1'b0, '0);
			end
			// hold the command side until the stack has caught up
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("rpn_four_level_stack_alu verification clean");
		else
			$display("rpn_four_level_stack_alu verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rsalu_pkg.sv
rtl/rsalu_stream_if.sv
rtl/rsalu_iter_unit.sv
rtl/rpn_four_level_stack_alu.sv
test/rpn_four_level_stack_alu_tb.sv
